// File: hdl/hhbf_pkg.sv
// Package for the HTTP header and body framer.
// Holds phase, scan and error codes plus byte-class helper functions.
// No dependencies.
package hhbf_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int LINE_BITS_DEF   = 16;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_FIXED  = 3'd1,
    PH_CSIZE  = 3'd2,
    PH_CDATA  = 3'd3,
    PH_CCRLF  = 3'd4,
    PH_FINAL  = 3'd5,
    PH_ERROR  = 3'd6
  } phase_t;

  localparam logic [3:0] SC_LEAD   = 4'd0;
  localparam logic [3:0] SC_SIGN   = 4'd1;
  localparam logic [3:0] SC_ZERO   = 4'd2;
  localparam logic [3:0] SC_DIGITS = 4'd3;
  localparam logic [3:0] SC_STOP   = 4'd5;
  localparam logic [3:0] SC_BAD    = 4'd6;
  localparam logic [3:0] CK_MATCH  = 4'd7;
  localparam logic [3:0] CK_FAIL   = 4'd8;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_LINE_LONG  = 4'd1;
  localparam logic [3:0] ERR_TOO_MANY   = 4'd2;
  localparam logic [3:0] ERR_NO_COLON   = 4'd3;
  localparam logic [3:0] ERR_EMPTY_NAME = 4'd4;
  localparam logic [3:0] ERR_BAD_LEN    = 4'd5;
  localparam logic [3:0] ERR_TOO_LARGE  = 4'd6;
  localparam logic [3:0] ERR_BAD_CHUNK  = 4'd7;
  localparam logic [3:0] ERR_CHUNK_CRLF = 4'd8;
  localparam logic [3:0] ERR_FINAL_CRLF = 4'd9;

  localparam logic [1:0] CFG_MAX_LINE   = 2'd0;
  localparam logic [1:0] CFG_MAX_HEADER = 2'd1;
  localparam logic [1:0] CFG_MAX_BODY   = 2'd2;

  localparam logic [4:0] TE_LEN = 5'd17;
  localparam logic [4:0] CL_LEN = 5'd14;

  function automatic logic [7:0] te_char(input logic [4:0] i);
    case (i)
      5'd0: te_char = "t";  5'd1: te_char = "r";  5'd2: te_char = "a";
      5'd3: te_char = "n";  5'd4: te_char = "s";  5'd5: te_char = "f";
      5'd6: te_char = "e";  5'd7: te_char = "r";  5'd8: te_char = "-";
      5'd9: te_char = "e";  5'd10: te_char = "n"; 5'd11: te_char = "c";
      5'd12: te_char = "o"; 5'd13: te_char = "d"; 5'd14: te_char = "i";
      5'd15: te_char = "n"; 5'd16: te_char = "g";
      default: te_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] cl_char(input logic [4:0] i);
    case (i)
      5'd0: cl_char = "c";  5'd1: cl_char = "o";  5'd2: cl_char = "n";
      5'd3: cl_char = "t";  5'd4: cl_char = "e";  5'd5: cl_char = "n";
      5'd6: cl_char = "t";  5'd7: cl_char = "-";  5'd8: cl_char = "l";
      5'd9: cl_char = "e";  5'd10: cl_char = "n"; 5'd11: cl_char = "g";
      5'd12: cl_char = "t"; 5'd13: cl_char = "h";
      default: cl_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ck_char(input logic [3:0] i);
    case (i)
      4'd0: ck_char = "c"; 4'd1: ck_char = "h"; 4'd2: ck_char = "u";
      4'd3: ck_char = "n"; 4'd4: ck_char = "k"; 4'd5: ck_char = "e";
      4'd6: ck_char = "d";
      default: ck_char = 8'h00;
    endcase
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    to_lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

endpackage

// File: hdl/hhbf_stream_if.sv
// Valid/ready stream interface with a parameterized payload type.
// Depends on nothing.
interface hhbf_stream_if #(parameter type payload_t = logic [7:0]) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/http_header_and_body_framer.sv
// HTTP header and body framer: header line checks and body extraction.
// Uses hhbf_pkg and hhbf_stream_if.
//
// Usage: feed the bytes after the start line on the input channel, one byte
// per transaction (payload data_byte). Each byte gives exactly one result
// transaction with body_valid/body_byte, message_done, error_flag and
// error_code. Limits come through the cfg_ port (index 0 line length,
// 1 header count, 2 body length), written while the block is idle.
// The result is registered and appears in the cycle after the byte is taken.
// Throughput: one byte per cycle when the output is not stalled; all per-byte work is one pass through the
// header/number scanners between the input and the output register, and the
// next byte's work depends on state updated in that same cycle.
// Reset (rst_n low, synchronous) returns limits to 8192/100/1048576, clears
// all framing state and any sticky error.
// Stall: while out_ready is low the result register holds; in_ready follows
// out_ready or an empty result register, so no byte is lost.
// Errors are sticky: later bytes each still give a result carrying the code.
module http_header_and_body_framer #(
  parameter int LENGTH_BITS = hhbf_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS   = hhbf_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  hhbf_stream_if.sink   in_if,
  hhbf_stream_if.source out_if
);
  import hhbf_pkg::*;

  // value accumulator width: one extra bit to hold the saturated cap
  localparam int VW = LENGTH_BITS + 1;
  localparam int LW = LINE_BITS + 1;
  // compare width for values against the 32-bit body limit
  localparam int MW = (VW > 33) ? VW : 33;
  localparam logic [VW-1:0] CAP  = {1'b1, {LENGTH_BITS{1'b0}}};
  localparam logic [LW-1:0] LCAP = {1'b1, {LINE_BITS{1'b0}}};

  logic [15:0] max_line_r;
  logic [7:0]  max_hdr_r;
  logic [31:0] max_body_r;

  phase_t        phase_r, phase_nxt;
  logic          pcr_r, pcr_nxt;
  logic [LW-1:0] llen_r, llen_nxt;
  logic [7:0]    hcnt_r, hcnt_nxt;
  logic          colon_r, colon_nxt, empty_r, empty_nxt, neg_r, neg_nxt;
  logic [4:0]    nidx_r, nidx_nxt;
  logic [1:0]    nmask_r, nmask_nxt;
  logic [3:0]    scan_r, scan_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic          chunked_r, chunked_nxt;
  logic [1:0]    lseen_r, lseen_nxt;
  logic [VW-1:0] clv_r, clv_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic          fidx_r, fidx_nxt;
  logic [3:0]    err_r, err_nxt;

  logic        ovld_r;
  logic        bv_r, bv_nxt, done_r, done_nxt;
  logic [7:0]  bb_r, bb_nxt;

  logic       take;
  logic [7:0] b;

  assign in_if.ready = !ovld_r || out_if.ready;
  assign take        = in_if.valid && in_if.ready;
  assign b           = in_if.payload;

  assign out_if.valid                = ovld_r;
  assign out_if.payload.body_valid   = bv_r;
  assign out_if.payload.body_byte    = bb_r;
  assign out_if.payload.message_done = done_r;
  assign out_if.payload.error_flag   = (phase_r == PH_ERROR);
  assign out_if.payload.error_code   = (phase_r == PH_ERROR) ? err_r : ERR_NONE;

  // digit value of a byte, base 10 or 16; bit 4 set means no digit
  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
    logic [7:0] l;
    l = to_lower(c);
    if (c >= "0" && c <= "9") digit_of = {1'b0, 4'(c - "0")};
    else if (hex && l >= "a" && l <= "f") digit_of = {1'b0, 4'(l - "a" + 8'd10)};
    else digit_of = 5'h10;
  endfunction

  // saturating v*base+d; product fits in VW+4 bits
  function automatic logic [VW-1:0] acc(input logic [VW-1:0] v, input logic [3:0] d,
                                        input logic hex);
    logic [VW+3:0] p;
    p = hex ? {v, 4'b0} : ({3'b0, v, 1'b0} + {1'b0, v, 3'b0});
    p = p + (VW+4)'(d);
    if (v >= CAP || p >= (VW+4)'(CAP)) acc = CAP;
    else acc = p[VW-1:0];
  endfunction

  // one step of the numeric scanner, works on the _nxt copies
  task automatic scan_num(input logic [7:0] c, input logic hex,
                          inout logic [3:0] st, inout logic [VW-1:0] v, inout logic ng);
    logic [4:0] d;
    logic       lead;
    d = digit_of(c, hex);
    lead = 1'b0;
    case (st)
      SC_LEAD: begin
        if (is_ws(c)) ;
        else if (c == "+") st = SC_SIGN;
        else if (c == "-") begin st = SC_SIGN; ng = 1'b1; end
        else lead = 1'b1;
      end
      SC_SIGN: lead = 1'b1;
      SC_ZERO: begin
        if (c == "x" || c == "X") st = SC_DIGITS;
        else if (!d[4]) begin v = acc(v, d[3:0], hex); st = SC_DIGITS; end
        else st = SC_STOP;
      end
      SC_DIGITS: begin
        if (!d[4]) v = acc(v, d[3:0], hex);
        else st = SC_STOP;
      end
      default: ;
    endcase
    if (lead) begin
      if (d[4]) st = SC_BAD;
      else if (hex && c == "0") begin v = '0; st = SC_ZERO; end
      else begin v = acc(v, d[3:0], hex); st = SC_DIGITS; end
    end
  endtask

  logic [VW-1:0] sres;
  logic          svalid;
  assign svalid = (scan_r == SC_ZERO) || (scan_r == SC_DIGITS) || (scan_r == SC_STOP);
  assign sres   = (neg_r && val_r != '0) ? CAP : val_r;

  // per-byte next state
  always_comb begin
    logic [7:0] c;
    logic       data, lnend;
    phase_nxt = phase_r;   pcr_nxt = pcr_r;     llen_nxt = llen_r;
    hcnt_nxt = hcnt_r;     colon_nxt = colon_r; empty_nxt = empty_r;
    neg_nxt = neg_r;       nidx_nxt = nidx_r;   nmask_nxt = nmask_r;
    scan_nxt = scan_r;     val_nxt = val_r;     chunked_nxt = chunked_r;
    lseen_nxt = lseen_r;   clv_nxt = clv_r;     rem_nxt = rem_r;
    fidx_nxt = fidx_r;     err_nxt = err_r;
    bv_nxt = 1'b0; bb_nxt = 8'h00; done_nxt = 1'b0;
    c = b; data = 1'b0; lnend = 1'b0;

    case (phase_r)
      PH_HEADER, PH_CSIZE: begin
        if (pcr_r) begin
          pcr_nxt = 1'b0;
          if (b == 8'h0A) lnend = 1'b1;
        end
        if (!lnend) begin
          // a CR pending but not followed by LF is line data, then b
          if (pcr_r && b == 8'h0D) begin c = 8'h0D; data = 1'b1; pcr_nxt = 1'b1; end
          else if (pcr_r) begin c = 8'h0D; data = 1'b1; end
          else if (b == 8'h0D) pcr_nxt = 1'b1;
          else data = 1'b1;
        end
      end
      PH_FIXED, PH_CDATA: begin
        bv_nxt = 1'b1; bb_nxt = b;
        if (rem_r != '0) rem_nxt = rem_r - 1'b1;
        if (rem_nxt == '0) begin
          if (phase_r == PH_FIXED) done_nxt = 1'b1;
          else begin phase_nxt = PH_CCRLF; fidx_nxt = 1'b0; end
        end
      end
      PH_CCRLF, PH_FINAL: begin
        if (!fidx_r) begin
          if (b == 8'h0D) fidx_nxt = 1'b1;
          else begin
            phase_nxt = PH_ERROR;
            err_nxt = (phase_r == PH_CCRLF) ? ERR_CHUNK_CRLF : ERR_FINAL_CRLF;
          end
        end else if (b != 8'h0A) begin
          phase_nxt = PH_ERROR;
          err_nxt = (phase_r == PH_CCRLF) ? ERR_CHUNK_CRLF : ERR_FINAL_CRLF;
        end else if (phase_r == PH_CCRLF) begin
          phase_nxt = PH_CSIZE; fidx_nxt = 1'b0;
        end else done_nxt = 1'b1;
      end
      default: ;
    endcase

    // a CR-then-non-LF pair carries two data bytes; the CR is handled here,
    // and a following non-CR byte in the second pass below
    if (data) begin
      if (phase_r == PH_HEADER) begin
        if (llen_nxt < LCAP) llen_nxt = llen_nxt + 1'b1;
        if (!colon_nxt) begin
          if (c == ":") begin
            colon_nxt = 1'b1;
            if (llen_r == '0 && !(pcr_r && c != b)) empty_nxt = 1'b1;
            nmask_nxt = {nmask_nxt[1] && nidx_nxt == CL_LEN,
                         nmask_nxt[0] && nidx_nxt == TE_LEN};
            scan_nxt = SC_LEAD; val_nxt = '0;
          end else begin
            if (nidx_nxt >= TE_LEN || c != te_char(nidx_nxt)) nmask_nxt[0] = 1'b0;
            if (nidx_nxt >= CL_LEN || c != cl_char(nidx_nxt)) nmask_nxt[1] = 1'b0;
            if (nidx_nxt != 5'd31) nidx_nxt = nidx_nxt + 1'b1;
          end
        end else if (nmask_nxt[0]) begin
          if (scan_nxt == SC_LEAD) begin
            if (!is_ws(c)) scan_nxt = (to_lower(c) == "c") ? 4'd1 : CK_FAIL;
          end else if (scan_nxt < CK_MATCH) begin
            scan_nxt = (to_lower(c) == ck_char(scan_nxt)) ? scan_nxt + 1'b1 : CK_FAIL;
          end else if (scan_nxt == CK_MATCH) begin
            if (!is_ws(c)) scan_nxt = CK_FAIL;
          end
        end else if (nmask_nxt[1]) begin
          scan_num(c, 1'b0, scan_nxt, val_nxt, neg_nxt);
        end
      end else begin
        scan_num(c, 1'b1, scan_nxt, val_nxt, neg_nxt);
      end
      // second byte after a dangling CR (not itself a CR)
      if (pcr_r && b != 8'h0D) begin
        c = b;
        if (phase_r == PH_HEADER) begin
          if (llen_nxt < LCAP) llen_nxt = llen_nxt + 1'b1;
          if (!colon_nxt) begin
            if (c == ":") begin
              colon_nxt = 1'b1;
              nmask_nxt = {nmask_nxt[1] && nidx_nxt == CL_LEN,
                           nmask_nxt[0] && nidx_nxt == TE_LEN};
              scan_nxt = SC_LEAD; val_nxt = '0;
            end else begin
              if (nidx_nxt >= TE_LEN || c != te_char(nidx_nxt)) nmask_nxt[0] = 1'b0;
              if (nidx_nxt >= CL_LEN || c != cl_char(nidx_nxt)) nmask_nxt[1] = 1'b0;
              if (nidx_nxt != 5'd31) nidx_nxt = nidx_nxt + 1'b1;
            end
          end else if (nmask_nxt[0]) begin
            if (scan_nxt == SC_LEAD) begin
              if (!is_ws(c)) scan_nxt = (to_lower(c) == "c") ? 4'd1 : CK_FAIL;
            end else if (scan_nxt < CK_MATCH) begin
              scan_nxt = (to_lower(c) == ck_char(scan_nxt)) ? scan_nxt + 1'b1 : CK_FAIL;
            end else if (scan_nxt == CK_MATCH) begin
              if (!is_ws(c)) scan_nxt = CK_FAIL;
            end
          end else if (nmask_nxt[1]) begin
            scan_num(c, 1'b0, scan_nxt, val_nxt, neg_nxt);
          end
        end else begin
          scan_num(c, 1'b1, scan_nxt, val_nxt, neg_nxt);
        end
      end
    end

    // end of a line: header checks or chunk size decode
    if (lnend) begin
      if (phase_r == PH_HEADER) begin
        if (llen_r == '0) begin
          if (chunked_r) phase_nxt = PH_CSIZE;
          else if (lseen_r == 2'd2) begin phase_nxt = PH_ERROR; err_nxt = ERR_BAD_LEN; end
          else if (lseen_r == 2'd1 && clv_r != '0) begin
            if (clv_r >= CAP || MW'(clv_r) > MW'(max_body_r)) begin
              phase_nxt = PH_ERROR; err_nxt = ERR_TOO_LARGE;
            end else begin
              rem_nxt = clv_r[LENGTH_BITS-1:0]; phase_nxt = PH_FIXED;
            end
          end else done_nxt = 1'b1;
        end else if (hcnt_r >= max_hdr_r) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_TOO_MANY;
        end else if (llen_r >= LCAP || 32'(llen_r) > 32'(max_line_r)) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_LINE_LONG;
        end else if (!colon_r) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_NO_COLON;
        end else if (empty_r) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_EMPTY_NAME;
        end else begin
          if (nmask_r[0]) chunked_nxt = (scan_r == CK_MATCH);
          if (nmask_r[1]) begin
            if (scan_r == SC_LEAD) begin lseen_nxt = 2'd0; clv_nxt = '0; end
            else if (svalid) begin lseen_nxt = 2'd1; clv_nxt = sres; end
            else begin lseen_nxt = 2'd2; clv_nxt = '0; end
          end
          hcnt_nxt = hcnt_r + 1'b1;
        end
      end else begin
        if (!svalid) begin phase_nxt = PH_ERROR; err_nxt = ERR_BAD_CHUNK; end
        else if (sres >= CAP || MW'(sres) > MW'(max_body_r)) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_TOO_LARGE;
        end else if (sres == '0) phase_nxt = PH_FINAL;
        else begin rem_nxt = sres[LENGTH_BITS-1:0]; phase_nxt = PH_CDATA; end
      end
    end

    // clear per-line state on any line change that leaves no error
    if (phase_nxt != PH_ERROR &&
        (lnend || (phase_r == PH_CCRLF && phase_nxt == PH_CSIZE) ||
         (phase_r != phase_nxt && phase_nxt == PH_FIXED))) begin
      llen_nxt = '0; colon_nxt = 1'b0; empty_nxt = 1'b0; neg_nxt = 1'b0;
      nidx_nxt = '0; nmask_nxt = 2'b11; scan_nxt = SC_LEAD; val_nxt = '0;
      fidx_nxt = 1'b0; pcr_nxt = 1'b0;
    end

    // message complete: clear everything per message
    if (done_nxt) begin
      phase_nxt = PH_HEADER; pcr_nxt = 1'b0; llen_nxt = '0; hcnt_nxt = '0;
      colon_nxt = 1'b0; empty_nxt = 1'b0; neg_nxt = 1'b0; nidx_nxt = '0;
      nmask_nxt = 2'b11; scan_nxt = SC_LEAD; val_nxt = '0; chunked_nxt = 1'b0;
      lseen_nxt = '0; clv_nxt = '0; rem_nxt = '0; fidx_nxt = 1'b0;
    end
  end

  // state, config and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_r <= 16'd8192; max_hdr_r <= 8'd100; max_body_r <= 32'd1048576;
      phase_r <= PH_HEADER; pcr_r <= 1'b0; llen_r <= '0; hcnt_r <= '0;
      colon_r <= 1'b0; empty_r <= 1'b0; neg_r <= 1'b0; nidx_r <= '0;
      nmask_r <= 2'b11; scan_r <= SC_LEAD; val_r <= '0; chunked_r <= 1'b0;
      lseen_r <= '0; clv_r <= '0; rem_r <= '0; fidx_r <= 1'b0; err_r <= ERR_NONE;
      ovld_r <= 1'b0; bv_r <= 1'b0; bb_r <= '0; done_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_LINE:   max_line_r <= cfg_wdata[15:0];
          CFG_MAX_HEADER: max_hdr_r  <= cfg_wdata[7:0];
          CFG_MAX_BODY:   max_body_r <= cfg_wdata;
          default: ;
        endcase
      end
      // hold the result until it is taken, load a new one on each input
      ovld_r <= take || (ovld_r && !out_if.ready);
      if (take) begin
        bv_r <= bv_nxt; bb_r <= bb_nxt; done_r <= done_nxt;
        phase_r <= phase_nxt; pcr_r <= pcr_nxt; llen_r <= llen_nxt;
        hcnt_r <= hcnt_nxt; colon_r <= colon_nxt; empty_r <= empty_nxt;
        neg_r <= neg_nxt; nidx_r <= nidx_nxt; nmask_r <= nmask_nxt;
        scan_r <= scan_nxt; val_r <= val_nxt; chunked_r <= chunked_nxt;
        lseen_r <= lseen_nxt; clv_r <= clv_nxt; rem_r <= rem_nxt;
        fidx_r <= fidx_nxt; err_r <= err_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a body byte never comes with an error
  a_body_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && bv_r |-> phase_r != PH_ERROR) else $error("body byte in error phase");
  // error phase is sticky
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |=> phase_r == PH_ERROR) else $error("error phase left");
  // done returns to header phase
  a_done_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    take && done_nxt |=> phase_r == PH_HEADER) else $error("done without restart");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && !out_if.ready |=> ovld_r && $stable(bb_r)) else $error("result dropped");
`endif

endmodule
